// ----- hw/rtl/ksfp_pkg.sv -----
package ksfp_pkg;

   // Progress of one key matcher through its value.
   typedef enum logic [2:0] {
      PH_SEARCH,
      PH_SKIP,
      PH_VALUE,
      PH_SIGNED,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   localparam int KEY_COUNT = 6;
   localparam int KEY_POS   = 0;
   localparam int KEY_SPEED = 5;
   localparam int FLAG_COUNT = 4;

   localparam int POS_MAX_BYTES = 31;
   localparam int POS_VEC_W     = 8 * POS_MAX_BYTES;
   localparam int RSP_FIELDS_W  = POS_VEC_W + 5 + FLAG_COUNT + 8;
   localparam int RSP_DATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_ONE    = 8'h31;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_NUL    = 8'h00;

   // Key letters in matcher order: position, referenced, busy, back, front, speed.
   localparam logic [7:0] KEY_LETTERS [KEY_COUNT] = '{8'h70, 8'h72, 8'h62, 8'h6F, 8'h75, 8'h76};

endpackage

// ----- hw/rtl/ksfp_key_match.sv -----
module ksfp_key_match #(
   parameter logic [7:0] LETTER = 8'h70
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       clear,
   input  logic       step,
   input  logic [7:0] data,
   output logic       hit
);
   import ksfp_pkg::*;

   // Number of key bytes matched so far; a full match is reported through hit.
   logic [1:0] progress_ff;
   logic [1:0] progress_in;

   assign hit = (progress_ff == 2'd3) && (data == CH_COLON);

   // Longest key prefix that ends at the current byte, so overlapping keys are found.
   always_comb begin
      progress_in = 2'd0;
      case (progress_ff)
         2'd0: begin
            if (data == CH_QUOTE) progress_in = 2'd1;
         end
         2'd1: begin
            if (data == LETTER) progress_in = 2'd2;
            else if (data == CH_QUOTE) progress_in = 2'd1;
         end
         2'd2: begin
            if (data == CH_QUOTE) progress_in = 2'd3;
         end
         2'd3: begin
            if (data == LETTER) progress_in = 2'd2;
            else if (data == CH_QUOTE) progress_in = 2'd1;
         end
         default: progress_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         progress_ff <= 2'd0;
      end else if (step) begin
         progress_ff <= progress_in;
      end
   end

endmodule

// ----- hw/rtl/keyed_status_frame_parser.sv -----
// Result: a word is registered once the frame's last byte leaves the input register.
// Throughput: one byte per cycle through a single registered pass; a frame's last byte
// waits in the input register only while the previous result is still held.
// Reset: synchronous, active high; clears all matchers, the frame state and both
// valid flags. A result also returns the frame state to its reset value.
module keyed_status_frame_parser #(
   parameter int POSITION_BYTES = 31
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [7:0] data_byte
   input  logic                              req_tlast,  // frame_end
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [63:0] position_word0, [127:64] position_word1, [191:128] position_word2,
   // [247:192] position_word3, [252:248] position_length, [253] referenced_flag,
   // [254] busy_flag, [255] back_switch, [256] front_switch, [264:257] speed_value,
   // [271:265] zero
   output logic [ksfp_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import ksfp_pkg::*;

   // Input register: holds one byte until the parse stage takes it.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // The parse stage advances unless a frame end would overwrite a result that
   // is still waiting on the result side.
   logic advance;
   logic live;
   logic frame_done;

   assign advance    = in_valid_ff && (!in_last_ff || !rsp_tvalid || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign frame_done = advance && in_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Frame state.
   logic                   text_ended_ff, text_ended_in;
   phase_type              phase_ff [KEY_COUNT];
   phase_type              phase_in [KEY_COUNT];
   logic [7:0]             store_ff [POSITION_BYTES];
   logic [7:0]             store_in [POSITION_BYTES];
   logic [4:0]             count_ff, count_in;
   logic [FLAG_COUNT-1:0]  flags_ff, flags_in;
   logic [31:0]            acc_ff, acc_in;
   logic                   neg_ff, neg_in;
   logic                   ovf_ff, ovf_in;

   // Bytes after the first zero byte are ignored until frame end.
   assign live = advance && !text_ended_ff && (in_byte_ff != CH_NUL);

   logic [KEY_COUNT-1:0] key_hit;

   for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
      ksfp_key_match #(
         .LETTER(KEY_LETTERS[k])
      ) u_key_match (
         .clock (clock),
         .reset (reset),
         .clear (frame_done),
         .step  (live && (phase_ff[k] == PH_SEARCH)),
         .data  (in_byte_ff),
         .hit   (key_hit[k])
      );
   end

   // Byte classes used by the value parsers.
   logic        is_digit;
   logic        is_ws;
   logic        is_skip;
   logic [35:0] acc_next_wide;

   assign is_digit = (in_byte_ff inside {[CH_ZERO:CH_NINE]});
   assign is_ws    = (in_byte_ff inside {CH_SPACE, [CH_TAB:CH_CR]});
   assign is_skip  = (in_byte_ff == CH_SPACE) || (in_byte_ff == CH_COLON);

   // acc * 10 + digit as two shifted copies and two adds.
   assign acc_next_wide = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1)
                        + {32'd0, in_byte_ff[3:0]};

   always_comb begin
      phase_type sp;
      logic      pos_take;
      text_ended_in = text_ended_ff;
      for (int k = 0; k < KEY_COUNT; k++) phase_in[k] = phase_ff[k];
      for (int i = 0; i < POSITION_BYTES; i++) store_in[i] = store_ff[i];
      count_in = count_ff;
      flags_in = flags_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      sp       = phase_ff[KEY_SPEED];
      pos_take = 1'b0;

      if (advance && !text_ended_ff && (in_byte_ff == CH_NUL)) begin
         text_ended_in = 1'b1;
      end

      if (live) begin
         // Position: copy bytes until a comma, a closing brace or a full store.
         case (phase_ff[KEY_POS])
            PH_SEARCH: begin
               if (key_hit[KEY_POS]) phase_in[KEY_POS] = PH_SKIP;
            end
            PH_SKIP: begin
               if (!is_skip) pos_take = 1'b1;
            end
            PH_VALUE: pos_take = 1'b1;
            default: ;
         endcase
         if (pos_take) begin
            if ((in_byte_ff == CH_COMMA) || (in_byte_ff == CH_RBRACE)
                  || (count_ff >= 5'(POSITION_BYTES))) begin
               phase_in[KEY_POS] = PH_DONE;
            end else begin
               for (int i = 0; i < POSITION_BYTES; i++) begin
                  if (count_ff == 5'(i)) store_in[i] = in_byte_ff;
               end
               count_in = count_ff + 5'd1;
               phase_in[KEY_POS] = (count_in >= 5'(POSITION_BYTES)) ? PH_DONE : PH_VALUE;
            end
         end

         // Flags: the first byte after the skipped spaces and colons decides.
         for (int k = 1; k <= FLAG_COUNT; k++) begin
            case (phase_ff[k])
               PH_SEARCH: begin
                  if (key_hit[k]) phase_in[k] = PH_SKIP;
               end
               PH_SKIP: begin
                  if (!is_skip) begin
                     if (in_byte_ff == CH_ONE) flags_in[k-1] = 1'b1;
                     phase_in[k] = PH_DONE;
                  end
               end
               PH_DONE: ;
               default: phase_in[k] = PH_DONE;
            endcase
         end

         // Speed: whitespace, one optional sign, then decimal digits.
         if ((sp == PH_SKIP) && !is_skip) sp = PH_VALUE;
         case (sp)
            PH_SEARCH: begin
               if (key_hit[KEY_SPEED]) phase_in[KEY_SPEED] = PH_SKIP;
            end
            PH_SKIP: ;
            PH_DONE: ;
            default: begin
               phase_in[KEY_SPEED] = sp;
               if ((sp == PH_VALUE) && is_ws) begin
                  phase_in[KEY_SPEED] = PH_VALUE;
               end else if ((sp == PH_VALUE)
                     && ((in_byte_ff == CH_PLUS) || (in_byte_ff == CH_MINUS))) begin
                  neg_in = (in_byte_ff == CH_MINUS);
                  phase_in[KEY_SPEED] = PH_SIGNED;
               end else if (is_digit) begin
                  phase_in[KEY_SPEED] = PH_DIGITS;
                  if (!ovf_ff) begin
                     if (acc_next_wide[35:32] != 4'd0) ovf_in = 1'b1;
                     else acc_in = acc_next_wide[31:0];
                  end
               end else begin
                  phase_in[KEY_SPEED] = PH_DONE;
               end
            end
         endcase
      end
   end

   // Control state returns to reset after every result.
   always_ff @(posedge clock) begin
      if (reset || frame_done) begin
         text_ended_ff <= 1'b0;
         for (int k = 0; k < KEY_COUNT; k++) phase_ff[k] <= PH_SEARCH;
         count_ff <= 5'd0;
         flags_ff <= '0;
         acc_ff   <= 32'd0;
         neg_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
      end else if (advance) begin
         text_ended_ff <= text_ended_in;
         for (int k = 0; k < KEY_COUNT; k++) phase_ff[k] <= phase_in[k];
         count_ff <= count_in;
         flags_ff <= flags_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         ovf_ff   <= ovf_in;
      end
   end

   // The store needs no clearing: only bytes below the count are shown.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < POSITION_BYTES; i++) store_ff[i] <= store_in[i];
      end
   end

   // Result packing from the updated state of the last byte.
   logic [POS_VEC_W-1:0]  pos_vec;
   logic [7:0]            speed_value;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   always_comb begin
      pos_vec = '0;
      for (int i = 0; i < POSITION_BYTES; i++) begin
         if (5'(i) < count_in) pos_vec[8*i +: 8] = store_in[i];
      end
   end

   always_comb begin
      if (ovf_in) speed_value = 8'hFF;
      else if (neg_in) speed_value = 8'd0 - acc_in[7:0];
      else speed_value = acc_in[7:0];
   end

   assign rsp_data_in = {{(RSP_DATA_W - RSP_FIELDS_W){1'b0}}, speed_value, flags_in,
                         count_in, pos_vec};

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (frame_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_done) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A new result appears only after a frame's last byte went through the parse stage.
   a_result_from_frame_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(frame_done))
      else $error("result raised without a processed frame end");

   // A frame end leaves the next frame with an empty state.
   a_frame_state_cleared: assert property (@(posedge clock) disable iff (reset)
      frame_done |=> (count_ff == 5'd0) && !text_ended_ff && !ovf_ff && (flags_ff == '0))
      else $error("frame state not cleared after result");

   // The position count stays within the store.
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 5'(POSITION_BYTES))
      else $error("position count beyond store depth");

   // Captured bytes imply the position key was found.
   a_count_needs_key: assert property (@(posedge clock) disable iff (reset)
      (count_ff != 5'd0) |->
         ((phase_ff[KEY_POS] == PH_VALUE) || (phase_ff[KEY_POS] == PH_DONE)))
      else $error("position bytes captured before key match");

endmodule

// ----- test/keyed_status_frame_parser_test.sv -----
`timescale 1ns / 100ps

module keyed_status_frame_parser_test;
   import ksfp_pkg::*;

   // Characters the frame builder needs that the package does not name.
   localparam logic [7:0] CH_LBRACE = 8'h7B;

   // Stimulus stops once this many bytes have been accepted and enough frames
   // have closed, so that several dozen status words come back.
   localparam int ITEM_TARGET  = 1000;
   localparam int FRAME_TARGET = 48;
   // Bytes near the end of the run that go without any idling.
   localparam int QUIET_TAIL   = 150;
   // Length of the long receiver hold-off that backs the parser up.
   localparam int HOLD_CYCLES  = 300;

   // One status word as the parser should emit it at the end of a frame.
   typedef struct {
      logic [63:0] word0;
      logic [63:0] word1;
      logic [63:0] word2;
      logic [55:0] word3;
      logic [4:0]  pos_len;
      logic        referenced;
      logic        busy;
      logic        back_sw;
      logic        front_sw;
      logic [7:0]  speed;
   } frame_status_type;

   // The checker keeps its own copy of the parser state. Every accepted byte
   // runs through six key matchers; a byte with tlast closes the frame, queues
   // the expected status word and clears the state for the next frame.
   class status_frame_checker;
      frame_status_type pending_status [$];
      int            mismatch_count;
      int            frames_checked;

      logic [2:0]    key_progress [KEY_COUNT];
      phase_type     phase [KEY_COUNT];
      bit            text_done;
      logic [7:0]    pos_store [POS_MAX_BYTES];
      int            pos_count;
      logic [3:0]    flags;
      logic [31:0]   speed_acc;
      bit            speed_neg;
      bit            speed_ovf;

      function new();
         mismatch_count = 0;
         frames_checked = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         for (int k = 0; k < KEY_COUNT; k++) begin
            key_progress[k] = '0;
            phase[k] = PH_SEARCH;
         end
         for (int i = 0; i < POS_MAX_BYTES; i++) pos_store[i] = '0;
         text_done = 1'b0;
         pos_count = 0;
         flags = '0;
         speed_acc = '0;
         speed_neg = 1'b0;
         speed_ovf = 1'b0;
      endfunction

      // Byte i of the four-byte key "k": quote, letter, quote, colon.
      function logic [7:0] key_byte(int k, int i);
         if (i == 1) return KEY_LETTERS[k];
         if (i == 3) return CH_COLON;
         return CH_QUOTE;
      endfunction

      // Longest key prefix that ends at the new byte, so that overlapping
      // keys such as a doubled quote are still found.
      function logic [2:0] advance_match(int k, int prog, logic [7:0] c);
         logic [7:0] seq [4];
         int         len;
         bit         ok;
         if (prog > 3) prog = 3;
         for (int i = 0; i < prog; i++) seq[i] = key_byte(k, i);
         seq[prog] = c;
         len = prog + 1;
         for (int n = len; n > 0; n--) begin
            ok = 1'b1;
            for (int i = 0; i < n; i++)
               if (seq[len - n + i] != key_byte(k, i)) ok = 1'b0;
            if (ok) return 3'(n);
         end
         return 3'd0;
      endfunction

      function void capture_position(logic [7:0] c);
         if (c == CH_COMMA || c == CH_RBRACE || pos_count >= POS_MAX_BYTES) begin
            phase[KEY_POS] = PH_DONE;
            return;
         end
         pos_store[pos_count] = c;
         pos_count++;
         if (pos_count >= POS_MAX_BYTES) phase[KEY_POS] = PH_DONE;
         else phase[KEY_POS] = PH_VALUE;
      endfunction

      function void add_speed_digit(logic [7:0] c);
         logic [63:0] wide;
         phase[KEY_SPEED] = PH_DIGITS;
         if (speed_ovf) return;
         wide = 64'(speed_acc) * 64'd10 + 64'(c - CH_ZERO);
         if (wide > 64'hFFFF_FFFF) speed_ovf = 1'b1;
         else speed_acc = wide[31:0];
      endfunction

      function void speed_char(logic [7:0] c);
         bit digit;
         digit = (c >= CH_ZERO && c <= CH_NINE);
         if (phase[KEY_SPEED] == PH_VALUE) begin
            // Tab through carriage return, and space, count as whitespace.
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
            if (c == CH_PLUS || c == CH_MINUS) begin
               speed_neg = (c == CH_MINUS);
               phase[KEY_SPEED] = PH_SIGNED;
            end else if (digit) begin
               add_speed_digit(c);
            end else begin
               phase[KEY_SPEED] = PH_DONE;
            end
         end else if (digit) begin
            add_speed_digit(c);
         end else begin
            phase[KEY_SPEED] = PH_DONE;
         end
      endfunction

      function void matcher_char(int k, logic [7:0] c);
         case (phase[k])
            PH_DONE: ;
            PH_SEARCH: begin
               key_progress[k] = advance_match(k, int'(key_progress[k]), c);
               if (key_progress[k] >= 3'd4) phase[k] = PH_SKIP;
            end
            PH_SKIP: begin
               if (c == CH_SPACE || c == CH_COLON) return;
               if (k == KEY_POS) begin
                  capture_position(c);
               end else if (k == KEY_SPEED) begin
                  phase[k] = PH_VALUE;
                  speed_char(c);
               end else begin
                  if (c == CH_ONE) flags[k - 1] = 1'b1;
                  phase[k] = PH_DONE;
               end
            end
            default: begin
               if (k == KEY_POS) capture_position(c);
               else if (k == KEY_SPEED) speed_char(c);
               else phase[k] = PH_DONE;
            end
         endcase
      endfunction

      // Notes one accepted input word.
      function void take_byte(logic [7:0] c, logic last);
         frame_status_type           st;
         logic [POS_VEC_W-1:0]       vec;
         logic [31:0]                neg_mag;
         if (!text_done) begin
            if (c == CH_NUL) text_done = 1'b1;
            else for (int k = 0; k < KEY_COUNT; k++) matcher_char(k, c);
         end
         if (!last) return;
         vec = '0;
         for (int i = 0; i < pos_count; i++) vec[8*i +: 8] = pos_store[i];
         st.word0 = vec[63:0];
         st.word1 = vec[127:64];
         st.word2 = vec[191:128];
         st.word3 = vec[247:192];
         st.pos_len = pos_count[4:0];
         st.referenced = flags[0];
         st.busy = flags[1];
         st.back_sw = flags[2];
         st.front_sw = flags[3];
         neg_mag = 32'd0 - speed_acc;
         if (speed_ovf) st.speed = 8'hFF;
         else if (speed_neg) st.speed = neg_mag[7:0];
         else st.speed = speed_acc[7:0];
         pending_status.push_back(st);
         clear_frame();
      endfunction

      task flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
         $display("MISMATCH status word %0d, %s: got %h, expected %h",
                  frames_checked, what, got, want);
         mismatch_count++;
      endtask

      // Checks one accepted status word against the oldest expectation.
      task check_status(logic [RSP_DATA_W-1:0] data);
         frame_status_type want;
         if (pending_status.size() == 0) begin
            flag_mismatch("word with no frame closed", data[63:0], 64'd0);
            return;
         end
         want = pending_status.pop_front();
         if (data[63:0] != want.word0)
            flag_mismatch("position_word0", data[63:0], want.word0);
         if (data[127:64] != want.word1)
            flag_mismatch("position_word1", data[127:64], want.word1);
         if (data[191:128] != want.word2)
            flag_mismatch("position_word2", data[191:128], want.word2);
         if (data[247:192] != want.word3)
            flag_mismatch("position_word3", 64'(data[247:192]), 64'(want.word3));
         if (data[252:248] != want.pos_len)
            flag_mismatch("position_length", 64'(data[252:248]), 64'(want.pos_len));
         if (data[253] != want.referenced)
            flag_mismatch("referenced_flag", 64'(data[253]), 64'(want.referenced));
         if (data[254] != want.busy)
            flag_mismatch("busy_flag", 64'(data[254]), 64'(want.busy));
         if (data[255] != want.back_sw)
            flag_mismatch("back_switch", 64'(data[255]), 64'(want.back_sw));
         if (data[256] != want.front_sw)
            flag_mismatch("front_switch", 64'(data[256]), 64'(want.front_sw));
         if (data[264:257] != want.speed)
            flag_mismatch("speed_value", 64'(data[264:257]), 64'(want.speed));
         frames_checked++;
      endtask
   endclass

   // Every input of the parser has a known value from time zero.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;  // [7:0] data_byte
   logic                  req_tlast = 1'b0;  // frame_end
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [63:0] position_word0, [127:64] position_word1, [191:128] position_word2,
   // [247:192] position_word3, [252:248] position_length, [253] referenced_flag,
   // [254] busy_flag, [255] back_switch, [256] front_switch, [264:257] speed_value
   logic [RSP_DATA_W-1:0] rsp_tdata;

   status_frame_checker board = new();

   // Shared controls between the sender and the receiver.
   bit idle_on = 1'b1;
   bit hold_request = 1'b0;
   int bytes_sent = 0;
   int frames_sent = 0;

   logic [7:0] frame_bytes [$];

   keyed_status_frame_parser #(
      .POSITION_BYTES(POS_MAX_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Both channels are watched at the rising edge. Everything read here only
   // changes through nonblocking updates, so the values seen are the ones that
   // held during the cycle that just ended. The status word is checked before
   // the new byte is noted so that the oldest expectation is always first.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_status(rsp_tdata);
         if (req_tvalid && req_tready) board.take_byte(req_tdata, req_tlast);
      end
   end

   // Offers one word and returns at the edge where it is taken. A random idle
   // burst may come first while idling is on. The valid stays high from one
   // word to the next when there is no burst, so it is never lowered and
   // raised within one time step.
   task automatic send_byte(input logic [7:0] value, input logic last);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      if (last) frames_sent++;
   endtask

   task automatic send_text(input string s, input bit last_at_end);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], last_at_end && (i == s.len() - 1));
   endtask

   // Sender pause: nothing is offered until every status word has come back.
   // The wait on the clock comes before the check, so the valid is not driven twice in one step.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending_status.size() != 0);
   endtask

   // Builds one random frame. Most frames are well formed key lists with
   // random values; some keys are broken, some pieces are noise, and a few
   // frames are plain random bytes. A zero byte now and then ends the text
   // early, so whatever follows it must be ignored.
   task automatic build_frame();
      int pieces;
      int kind;
      int count;
      frame_bytes.delete();
      if ($urandom_range(0, 9) == 0) begin
         count = $urandom_range(1, 12);
         repeat (count) frame_bytes.push_back(8'($urandom_range(0, 255)));
         return;
      end
      if ($urandom_range(0, 1)) frame_bytes.push_back(CH_LBRACE);
      pieces = $urandom_range(1, 7);
      repeat (pieces) begin
         kind = $urandom_range(0, 8);
         if (kind < KEY_COUNT) begin
            // An extra leading quote exercises the overlap in key matching.
            if ($urandom_range(0, 7) == 0) frame_bytes.push_back(CH_QUOTE);
            frame_bytes.push_back(CH_QUOTE);
            if ($urandom_range(0, 9) == 0)
               frame_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
            else
               frame_bytes.push_back(KEY_LETTERS[kind]);
            frame_bytes.push_back(CH_QUOTE);
            if ($urandom_range(0, 11) != 0) frame_bytes.push_back(CH_COLON);
            repeat ($urandom_range(0, 2))
               frame_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_COLON);
            if (kind == KEY_POS) begin
               // Mostly short positions, sometimes long enough to fill the store.
               count = ($urandom_range(0, 5) == 0) ? $urandom_range(28, 36)
                                                   : $urandom_range(0, 8);
               repeat (count) frame_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end else if (kind == KEY_SPEED) begin
               repeat ($urandom_range(0, 2))
                  frame_bytes.push_back($urandom_range(0, 1) ? CH_SPACE
                                        : 8'($urandom_range(CH_TAB, CH_CR)));
               case ($urandom_range(0, 3))
                  0: frame_bytes.push_back(CH_PLUS);
                  1: frame_bytes.push_back(CH_MINUS);
                  default: ;
               endcase
               // Long digit runs can push the value past 32 bits.
               count = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 13)
                                                   : $urandom_range(0, 4);
               repeat (count) frame_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
            end else begin
               case ($urandom_range(0, 3))
                  0, 1: frame_bytes.push_back(CH_ONE);
                  2: frame_bytes.push_back(CH_ZERO);
                  default: frame_bytes.push_back(8'($urandom_range(0, 255)));
               endcase
            end
         end else if (kind == 6) begin
            repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom_range(0, 255)));
         end else if (kind == 7) begin
            frame_bytes.push_back(($urandom_range(0, 3) == 0) ? CH_NUL : CH_SPACE);
         end else begin
            frame_bytes.push_back(CH_COMMA);
         end
         if ($urandom_range(0, 1)) frame_bytes.push_back(CH_COMMA);
      end
      if ($urandom_range(0, 1)) frame_bytes.push_back(CH_RBRACE);
   endtask

   // The receiver alternates random ready stretches with short idle bursts,
   // and once holds off for a long stretch when the sender asks for it.
   initial begin : receiver
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      bit paused_once;
      bit held_once;
      paused_once = 1'b0;
      held_once = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed frames: an all-ones byte alone in a frame gives an all-zero
      // word; a doubled quote before a key, a flag and a negative speed after
      // whitespace; a position that ends at once on a brace; and a zero byte
      // that ends the text so the key after it must be ignored.
      send_byte(8'hFF, 1'b1);
      send_text("\"\"r\":1,\"v\": -7", 1'b1);
      send_text("\"p\":}", 1'b1);
      send_byte(CH_NUL, 1'b0);
      send_text("\"b\":1", 1'b1);

      // Random frames.
      while (bytes_sent < ITEM_TARGET || frames_sent < FRAME_TARGET) begin
         if (!paused_once && frames_sent >= 12) begin
            paused_once = 1'b1;
            wait_for_drain();
         end
         if (!held_once && frames_sent >= 20) begin
            // One-byte frames while the receiver holds off fill the parser
            // until it stops taking input.
            held_once = 1'b1;
            hold_request = 1'b1;
            repeat (40) send_byte(8'($urandom_range(0, 255)), 1'b1);
         end
         if (bytes_sent >= ITEM_TARGET - QUIET_TAIL) idle_on = 1'b0;
         build_frame();
         for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      end

      // Wait for the last status words, then keep the clock running for anything stray;
      // a word is registered once its frame's last byte has left the input register.
      wait_for_drain();
      repeat (8) @(posedge clock);
      if (board.mismatch_count == 0 && board.pending_status.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // A correct run needs well under a tenth of this time.
   initial begin : watchdog
      #5000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/ksfp_pkg.sv
hw/rtl/ksfp_key_match.sv
hw/rtl/keyed_status_frame_parser.sv
test/keyed_status_frame_parser_test.sv
